>>> hw/rtl/dsaf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsaf_pkg
// Shared widths and register indexes of the display size fitter.
// ----------------------------------------------------------------------------
package dsaf_pkg;

	localparam int ASPECT_W = 22;
	localparam int OUT_W    = 16;
	localparam int FM_W     = 3;
	localparam int RM_W     = 8;
	localparam int IDX_W    = 3;

	localparam logic [IDX_W-1:0] REG_TARGET_WIDTH   = 3'd0;
	localparam logic [IDX_W-1:0] REG_TARGET_HEIGHT  = 3'd1;
	localparam logic [IDX_W-1:0] REG_FIT_METHOD     = 3'd2;
	localparam logic [IDX_W-1:0] REG_ROUND_MULTIPLE = 3'd3;
	localparam logic [IDX_W-1:0] REG_FIXED_ASPECT   = 3'd4;

endpackage

>>> hw/rtl/dsaf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsaf_div
// Pipelined restoring divider, STEP quotient bits per stage, with a side
// channel that travels alongside. Quotients beyond Q_W bits saturate.
// ----------------------------------------------------------------------------
module dsaf_div #(
	parameter int NUM_W  = 26,
	parameter int DEN_W  = 13,
	parameter int Q_W    = 26,
	parameter int STEP   = 2,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              src_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side,
	output logic              dst_valid,
	output logic [Q_W-1:0]    quo,
	output logic [DEN_W-1:0]  rem,
	output logic [SIDE_W-1:0] side_out
);

	localparam int NST = (Q_W + STEP - 1) / STEP;
	localparam int CW  = (NUM_W > DEN_W) ? NUM_W : DEN_W;

	logic [DEN_W-1:0]  rem_s  [NST];
	logic [Q_W-1:0]    quo_s  [NST];
	logic [DEN_W-1:0]  den_s  [NST];
	logic              ovf_s  [NST];
	logic              vld_s  [NST];
	logic [SIDE_W-1:0] side_s [NST];

	logic [DEN_W-1:0] r0;
	logic [Q_W-1:0]   x0;
	logic             ovf0;

	assign ovf0 = CW'(num >> Q_W) >= CW'(den);
	assign r0   = DEN_W'(num >> Q_W);
	assign x0   = num[Q_W-1:0];

	for (genvar s = 0; s < NST; s++) begin : g_stg
		logic [DEN_W-1:0]  r_in;
		logic [Q_W-1:0]    x_in;
		logic [DEN_W-1:0]  d_in;
		logic              o_in;
		logic              v_in;
		logic [SIDE_W-1:0] sd_in;
		logic [DEN_W-1:0]  r_nx;
		logic [Q_W-1:0]    x_nx;

		if (s == 0) begin : g_first
			assign r_in  = r0;
			assign x_in  = x0;
			assign d_in  = den;
			assign o_in  = ovf0;
			assign v_in  = src_valid;
			assign sd_in = side;
		end else begin : g_next
			assign r_in  = rem_s[s-1];
			assign x_in  = quo_s[s-1];
			assign d_in  = den_s[s-1];
			assign o_in  = ovf_s[s-1];
			assign v_in  = vld_s[s-1];
			assign sd_in = side_s[s-1];
		end

		always_comb begin
			logic [DEN_W:0] t;
			t    = '0;
			r_nx = r_in;
			x_nx = x_in;
			for (int k = 0; k < STEP; k++) begin
				if (s * STEP + k < Q_W) begin
					t = {r_nx, x_nx[Q_W-1]};
					if (t >= {1'b0, d_in}) begin
						t    = t - {1'b0, d_in};
						x_nx = {x_nx[Q_W-2:0], 1'b1};
					end else begin
						x_nx = {x_nx[Q_W-2:0], 1'b0};
					end
					r_nx = t[DEN_W-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else if (en) begin
				vld_s[s] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[s]  <= r_nx;
				quo_s[s]  <= x_nx;
				den_s[s]  <= d_in;
				ovf_s[s]  <= o_in;
				side_s[s] <= sd_in;
			end
		end
	end

	assign dst_valid = vld_s[NST-1];
	assign quo       = ovf_s[NST-1] ? '1 : quo_s[NST-1];
	assign rem       = rem_s[NST-1];
	assign side_out  = side_s[NST-1];

endmodule

>>> hw/rtl/display_size_aspect_fit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_size_aspect_fit
// Derives a new display size from a frame's stored and display sizes.
// ----------------------------------------------------------------------------
// One request enters per cycle unless the result side stalls. Its path runs
// through pipelined dividers that retire two quotient bits per stage: the
// derived-dimension divider, the aspect fitting divider and the round-up
// remainder dividers, one per dimension. A stall on the result side holds
// the whole pipeline. Registers are to be written only while no request is
// in flight.
// ----------------------------------------------------------------------------
module display_size_aspect_fit
	import dsaf_pkg::*;
#(
	parameter int DIM_BITS         = 13,
	parameter int ASPECT_FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [IDX_W-1:0]       cfg_index,
	input  logic [((DIM_BITS + 1 > ASPECT_W) ? DIM_BITS + 1 : ASPECT_W)-1:0] cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [DIM_BITS-1:0]    src_width,
	input  logic [DIM_BITS-1:0]    src_height,
	input  logic [DIM_BITS-1:0]    in_disp_width,
	input  logic [DIM_BITS-1:0]    in_disp_height,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_W-1:0]       out_disp_width,
	output logic [OUT_W-1:0]       out_disp_height,
	output logic                   config_error
);

	localparam int D      = DIM_BITS;
	localparam int F      = ASPECT_FRAC_BITS;
	localparam int D1     = D + 1;
	localparam int CLW    = OUT_W + 1;
	localparam int P1_W   = 2 * D;
	localparam int P2_W   = 3 * D;
	localparam int FP_W   = ASPECT_W + D;
	localparam int WFIX_W = FP_W + 1 - F;
	localparam int KW     = (P1_W > WFIX_W) ? P1_W : WFIX_W;
	localparam int XW     = (KW > CLW) ? KW : CLW;
	localparam int GW     = (FP_W > D + F) ? FP_W : D + F;
	localparam int FIXN_W = ((D + F + 1 > ASPECT_W) ? D + F + 1 : ASPECT_W) + 1;
	localparam int NUM2_W = (P2_W > FIXN_W) ? P2_W : FIXN_W;
	localparam int DEN2_W = (D > ASPECT_W + 1) ? D : ASPECT_W + 1;

	localparam logic [ASPECT_W-1:0] THRESH = ASPECT_W'(((1 << F) + 999) / 1000);
	localparam logic [FP_W:0]       HALF   = (FP_W + 1)'(1) << (F - 1);
	localparam logic [CLW-1:0]      CLAMP_V = CLW'(1) << OUT_W;

	typedef struct packed {
		logic [D-1:0]    sw;
		logic [D-1:0]    sh;
		logic [D-1:0]    dw;
		logic [D-1:0]    dh;
		logic [D-1:0]    w0;
		logic [D-1:0]    h0;
		logic [FP_W-1:0] fap;
		logic            dz;
	} side1_t;

	typedef struct packed {
		logic [P1_W-1:0]   w1;
		logic [P1_W-1:0]   h1;
		logic [P2_W-1:0]   pw;
		logic [P2_W-1:0]   ph;
		logic [D-1:0]      numa;
		logic [D-1:0]      dena;
		logic              fit;
		logic [D-1:0]      sw;
		logic [D-1:0]      sh;
		logic              fa_gt;
		logic [WFIX_W-1:0] wfix;
	} stage2_t;

	typedef struct packed {
		logic [KW-1:0] wk;
		logic [KW-1:0] hk;
		logic          to_w;
		logic          to_h;
	} side3_t;

	// configuration registers
	logic [D1-1:0]       tw_q;
	logic [D1-1:0]       th_q;
	logic [FM_W-1:0]     fm_q;
	logic [RM_W-1:0]     rm_q;
	logic [ASPECT_W-1:0] fa_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_q <= '1;
			th_q <= '1;
			fm_q <= '1;
			rm_q <= RM_W'(1);
			fa_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_TARGET_WIDTH:   tw_q <= cfg_data[D1-1:0];
				REG_TARGET_HEIGHT:  th_q <= cfg_data[D1-1:0];
				REG_FIT_METHOD:     fm_q <= cfg_data[FM_W-1:0];
				REG_ROUND_MULTIPLE: rm_q <= cfg_data[RM_W-1:0];
				REG_FIXED_ASPECT:   fa_q <= cfg_data[ASPECT_W-1:0];
				default: ;
			endcase
		end
	end

	// static decode of the registers
	logic tw_disp, tw_src, tw_lit, tw_dd, tw_dv;
	logic th_disp, th_src, th_lit, th_dd, th_dv;
	logic err, fixed, sel_w, sel_h, fit_en, no_round;

	assign tw_disp  = tw_q == '0;
	assign tw_src   = tw_q == '1;
	assign tw_lit   = !tw_q[D1-1] && !tw_disp;
	assign tw_dd    = tw_q == {{(D1-1){1'b1}}, 1'b0};
	assign tw_dv    = tw_q[D1-1] && !tw_src;
	assign th_disp  = th_q == '0;
	assign th_src   = th_q == '1;
	assign th_lit   = !th_q[D1-1] && !th_disp;
	assign th_dd    = th_q == {{(D1-1){1'b1}}, 1'b0};
	assign th_dv    = th_q[D1-1] && !th_src;
	assign err      = tw_dv && th_dv;
	assign fixed    = fa_q >= THRESH;
	assign sel_w    = tw_dv;
	assign sel_h    = th_dv && !tw_dv;
	assign fit_en   = !fm_q[FM_W-1];
	assign no_round = fixed || (rm_q < RM_W'(2));

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: base dimensions and derived-dimension product
	logic [D-1:0] w0, h0, ma, mb, den1;

	always_comb begin
		w0 = tw_disp ? in_disp_width : tw_src ? src_width : tw_lit ? tw_q[D-1:0] : '0;
		h0 = th_disp ? in_disp_height : th_src ? src_height : th_lit ? th_q[D-1:0] : '0;
		ma   = '0;
		mb   = '0;
		den1 = '0;
		if (sel_w) begin
			ma   = h0;
			mb   = tw_dd ? in_disp_width : src_width;
			den1 = tw_dd ? in_disp_height : src_height;
		end else if (sel_h) begin
			ma   = w0;
			mb   = th_dd ? in_disp_height : src_height;
			den1 = th_dd ? in_disp_width : src_width;
		end
	end

	logic            vld_s1;
	logic [P1_W-1:0] p1_s1;
	logic [D-1:0]    den1_s1;
	side1_t          sd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1    <= P1_W'(ma) * P1_W'(mb);
			den1_s1  <= den1;
			sd_s1.sw <= src_width;
			sd_s1.sh <= src_height;
			sd_s1.dw <= in_disp_width;
			sd_s1.dh <= in_disp_height;
			sd_s1.w0 <= w0;
			sd_s1.h0 <= h0;
			sd_s1.fap <= FP_W'(fa_q) * FP_W'(src_height);
			sd_s1.dz <= den1 == '0;
		end
	end

	logic            vld_d1;
	logic [P1_W-1:0] q1;
	logic [D-1:0]    r1;
	side1_t          sd_d1;

	dsaf_div #(
		.NUM_W (P1_W),
		.DEN_W (D),
		.Q_W   (P1_W),
		.STEP  (2),
		.SIDE_W($bits(side1_t))
	) u_div_derive (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.src_valid(vld_s1),
		.num      (p1_s1),
		.den      (den1_s1),
		.side     (sd_s1),
		.dst_valid(vld_d1),
		.quo      (q1),
		.rem      (r1),
		.side_out (sd_d1)
	);

	// stage 2: resolved size and fitting cross products
	logic [P1_W-1:0] w1, h1;
	logic [D-1:0]    numa, dena;
	logic [D+F-1:0]  swf;
	logic [FP_W:0]   fr;

	always_comb begin
		w1   = sel_w ? (sd_d1.dz ? '0 : q1) : P1_W'(sd_d1.w0);
		h1   = sel_h ? (sd_d1.dz ? '0 : q1) : P1_W'(sd_d1.h0);
		numa = fm_q[1] ? sd_d1.sh : sd_d1.dh;
		dena = fm_q[1] ? sd_d1.sw : sd_d1.dw;
		swf  = {sd_d1.sw, {F{1'b0}}};
		fr   = {1'b0, sd_d1.fap} + HALF;
	end

	logic    vld_s2;
	stage2_t st_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s2.w1    <= w1;
			st_s2.h1    <= h1;
			st_s2.pw    <= P2_W'(w1) * P2_W'(numa);
			st_s2.ph    <= P2_W'(h1) * P2_W'(dena);
			st_s2.numa  <= numa;
			st_s2.dena  <= dena;
			st_s2.fit   <= fit_en && (numa != '0) && (dena != '0);
			st_s2.sw    <= sd_d1.sw;
			st_s2.sh    <= sd_d1.sh;
			st_s2.fa_gt <= GW'(sd_d1.fap) > GW'(swf);
			st_s2.wfix  <= fr[FP_W:F];
		end
	end

	// stage 3: pick the dimension to divide
	logic [NUM2_W-1:0] num2;
	logic [DEN2_W-1:0] den2;
	side3_t            sd3;
	logic              div_h;

	always_comb begin
		div_h    = (st_s2.ph > st_s2.pw) != fm_q[0];
		num2     = '0;
		den2     = '0;
		sd3.to_w = 1'b0;
		sd3.to_h = 1'b0;
		if (fixed) begin
			if (st_s2.fa_gt) begin
				sd3.wk = KW'(st_s2.wfix);
				sd3.hk = KW'(st_s2.sh);
			end else begin
				sd3.wk   = KW'(st_s2.sw);
				sd3.hk   = '0;
				sd3.to_h = 1'b1;
				num2     = NUM2_W'(FIXN_W'({st_s2.sw, {(F + 1){1'b0}}}) + FIXN_W'(fa_q));
				den2     = DEN2_W'({fa_q, 1'b0});
			end
		end else begin
			sd3.wk = KW'(st_s2.w1);
			sd3.hk = KW'(st_s2.h1);
			if (st_s2.fit) begin
				if (div_h) begin
					sd3.to_h = 1'b1;
					num2     = NUM2_W'(st_s2.pw);
					den2     = DEN2_W'(st_s2.dena);
				end else begin
					sd3.to_w = 1'b1;
					num2     = NUM2_W'(st_s2.ph);
					den2     = DEN2_W'(st_s2.numa);
				end
			end
		end
	end

	logic              vld_s3;
	logic [NUM2_W-1:0] num2_s3;
	logic [DEN2_W-1:0] den2_s3;
	side3_t            sd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num2_s3 <= num2;
			den2_s3 <= den2;
			sd_s3   <= sd3;
		end
	end

	logic              vld_d2;
	logic [CLW-1:0]    q2;
	logic [DEN2_W-1:0] r2;
	side3_t            sd_d2;

	dsaf_div #(
		.NUM_W (NUM2_W),
		.DEN_W (DEN2_W),
		.Q_W   (CLW),
		.STEP  (2),
		.SIDE_W($bits(side3_t))
	) u_div_fit (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.src_valid(vld_s3),
		.num      (num2_s3),
		.den      (den2_s3),
		.side     (sd_s3),
		.dst_valid(vld_d2),
		.quo      (q2),
		.rem      (r2),
		.side_out (sd_d2)
	);

	// stage 4: clamp, anything past the output range saturates anyway
	logic [XW-1:0]  wx, hx;
	logic [CLW-1:0] wc, hc;

	always_comb begin
		wx = sd_d2.to_w ? XW'(q2) : XW'(sd_d2.wk);
		hx = sd_d2.to_h ? XW'(q2) : XW'(sd_d2.hk);
		wc = (wx > XW'(CLAMP_V)) ? CLAMP_V : CLW'(wx);
		hc = (hx > XW'(CLAMP_V)) ? CLAMP_V : CLW'(hx);
	end

	logic           vld_s4;
	logic [CLW-1:0] wc_s4, hc_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wc_s4 <= wc;
			hc_s4 <= hc;
		end
	end

	// round-up remainders, one lane per dimension
	logic            vld_mw, vld_mh;
	logic [CLW-1:0]  qw, qh, wv, hv;
	logic [RM_W-1:0] remw, remh;

	dsaf_div #(
		.NUM_W (CLW),
		.DEN_W (RM_W),
		.Q_W   (CLW),
		.STEP  (2),
		.SIDE_W(CLW)
	) u_mod_w (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.src_valid(vld_s4),
		.num      (wc_s4 - CLW'(1)),
		.den      (rm_q),
		.side     (wc_s4),
		.dst_valid(vld_mw),
		.quo      (qw),
		.rem      (remw),
		.side_out (wv)
	);

	dsaf_div #(
		.NUM_W (CLW),
		.DEN_W (RM_W),
		.Q_W   (CLW),
		.STEP  (2),
		.SIDE_W(CLW)
	) u_mod_h (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.src_valid(vld_s4),
		.num      (hc_s4 - CLW'(1)),
		.den      (rm_q),
		.side     (hc_s4),
		.dst_valid(vld_mh),
		.quo      (qh),
		.rem      (remh),
		.side_out (hv)
	);

	// stage 5: round up and saturate
	logic [CLW-1:0]   wr, hr;
	logic [OUT_W-1:0] wo, ho;

	always_comb begin
		if (no_round) begin
			wr = wv;
			hr = hv;
		end else begin
			wr = (wv == '0) ? CLW'(rm_q) : wv + CLW'(rm_q) - CLW'(1) - CLW'(remw);
			hr = (hv == '0) ? CLW'(rm_q) : hv + CLW'(rm_q) - CLW'(1) - CLW'(remh);
		end
		wo = wr[CLW-1] ? '1 : wr[OUT_W-1:0];
		ho = hr[CLW-1] ? '1 : hr[OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_mw;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_disp_width  <= err ? '0 : wo;
			out_disp_height <= err ? '0 : ho;
			config_error    <= err;
		end
	end

`ifndef SYNTH
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		vld_mw == vld_mh)
		else $error("remainder lanes out of step");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && config_error |-> out_disp_width == '0 && out_disp_height == '0)
		else $error("error result carries a size");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	a_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> wc_s4 <= CLAMP_V && hc_s4 <= CLAMP_V)
		else $error("clamp stage out of range");
`endif

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for display_size_aspect_fit. It writes each register
// setting while the block is idle, then sends directed and random size
// requests. A local fitter predicts each display size, and the results are
// compared in order. Both sides add random gaps, apart from the last phase.
// ----------------------------------------------------------------------------
module tb
	import dsaf_pkg::*;
;

	localparam int DIM_BITS = 13;
	localparam int AFB      = 16;
	localparam int CFG_W    = 22;
	localparam int LATENCY  = DIM_BITS + 23;

	typedef struct packed {
		logic [15:0] w;
		logic [15:0] h;
		logic        err;
	} fit_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wen = 1'b0;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [DIM_BITS-1:0] src_width = '0;
	logic [DIM_BITS-1:0] src_height = '0;
	logic [DIM_BITS-1:0] in_disp_width = '0;
	logic [DIM_BITS-1:0] in_disp_height = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [OUT_W-1:0]    out_disp_width;
	logic [OUT_W-1:0]    out_disp_height;
	logic                config_error;

	logic [13:0] tw_reg;
	logic [13:0] th_reg;
	logic [2:0]  fm_reg;
	logic [7:0]  rm_reg;
	logic [21:0] fa_reg;

	fit_result_t expected_sizes[$];
	int          fail_count = 0;
	int          sent_count = 0;
	int          got_count = 0;
	bit          idle_enable = 1'b1;
	bit          hold_sink = 1'b0;

	display_size_aspect_fit dut (.*);

	always #2 clk = ~clk;

	function automatic longint unsigned div_or_zero(longint unsigned a, longint unsigned b,
			longint unsigned c);
		if (c == 0)
			return 0;
		return a * b / c;
	endfunction

	function automatic longint unsigned up_to_multiple(longint unsigned v, longint unsigned r);
		if (r <= 1)
			return v;
		if (v == 0)
			return r;
		return v + (r - 1 - (v - 1) % r);
	endfunction

	function automatic fit_result_t predict_size(longint unsigned sw, longint unsigned sh,
			longint unsigned dw, longint unsigned dh);
		fit_result_t     r;
		longint          tw;
		longint          th;
		longint          fm;
		longint unsigned w;
		longint unsigned h;
		longint unsigned a;
		longint unsigned num;
		longint unsigned den;
		bit              taller;
		tw = longint'($signed(tw_reg));
		th = longint'($signed(th_reg));
		fm = longint'($signed(fm_reg));
		a = fa_reg;
		r = '0;
		if (tw < -3)
			tw = -3;
		if (th < -3)
			th = -3;
		if (tw < -1 && th < -1) begin
			r.err = 1'b1;
			return r;
		end
		if (a >= ((64'd1 << AFB) + 999) / 1000) begin
			if (a * sh > (sw << AFB)) begin
				w = (sh * a + (64'd1 << (AFB - 1))) >> AFB;
				h = sh;
			end else begin
				h = ((sw << (AFB + 1)) + a) / (2 * a);
				w = sw;
			end
		end else begin
			w = (tw == 0) ? dw : (tw == -1) ? sw : (tw > 0) ? longint'(tw) : 0;
			h = (th == 0) ? dh : (th == -1) ? sh : (th > 0) ? longint'(th) : 0;
			if (tw == -2)
				w = div_or_zero(h, dw, dh);
			if (tw == -3)
				w = div_or_zero(h, sw, sh);
			if (th == -2)
				h = div_or_zero(w, dh, dw);
			if (th == -3)
				h = div_or_zero(w, sh, sw);
			if (fm >= 0) begin
				num = fm[1] ? sh : dh;
				den = fm[1] ? sw : dw;
				if (num != 0 && den != 0) begin
					taller = h * den > w * num;
					if (taller != fm[0])
						h = w * num / den;
					else
						w = h * den / num;
				end
			end
			w = up_to_multiple(w, rm_reg);
			h = up_to_multiple(h, rm_reg);
		end
		r.w = (w > 65535) ? 16'hFFFF : w[15:0];
		r.h = (h > 65535) ? 16'hFFFF : h[15:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch on result %0d: %s got %0d expected %0d", got_count, what, got, want);
		fail_count++;
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, longint value);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_W-1:0];
		case (idx)
			REG_TARGET_WIDTH:   tw_reg = value[13:0];
			REG_TARGET_HEIGHT:  th_reg = value[13:0];
			REG_FIT_METHOD:     fm_reg = value[2:0];
			REG_ROUND_MULTIPLE: rm_reg = value[7:0];
			REG_FIXED_ASPECT:   fa_reg = value[21:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_sizes.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic set_all(longint tw, longint th, longint fm, longint rm, longint fa);
		wait_drained();
		write_reg(REG_TARGET_WIDTH, tw);
		write_reg(REG_TARGET_HEIGHT, th);
		write_reg(REG_FIT_METHOD, fm);
		write_reg(REG_ROUND_MULTIPLE, rm);
		write_reg(REG_FIXED_ASPECT, fa);
	endtask

	// called at a falling edge; returns at a falling edge after the transfer
	task automatic send_size(int sw, int sh, int dw, int dh);
		if (idle_enable && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 3)) @(negedge clk);
		in_valid = 1'b1;
		src_width <= sw[DIM_BITS-1:0];
		src_height <= sh[DIM_BITS-1:0];
		in_disp_width <= dw[DIM_BITS-1:0];
		in_disp_height <= dh[DIM_BITS-1:0];
		expected_sizes.push_back(predict_size(sw[DIM_BITS-1:0], sh[DIM_BITS-1:0],
			dw[DIM_BITS-1:0], dh[DIM_BITS-1:0]));
		do
			@(posedge clk);
		while (!in_ready);
		sent_count++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic int rand_dim();
		case ($urandom_range(0, 3))
			0: return $urandom_range(1, 16);
			1: return $urandom_range(8100, 8191);
			default: return $urandom_range(1, 8191);
		endcase
	endfunction

	function automatic longint rand_target();
		case ($urandom_range(0, 5))
			0: return -longint'($urandom_range(1, 3));
			1: return -longint'($urandom_range(4, 8192));
			2: return 0;
			3: return $urandom_range(1, 64);
			default: return $urandom_range(1, 8191);
		endcase
	endfunction

	always @(negedge clk) begin
		if (hold_sink)
			out_ready <= 1'b0;
		else if (idle_enable && $urandom_range(0, 5) == 0)
			out_ready <= 1'b0;
		else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		fit_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_sizes.size() == 0) begin
				$display("unexpected result transfer");
				fail_count++;
			end else begin
				want = expected_sizes.pop_front();
				if (out_disp_width !== want.w)
					report_mismatch("width", out_disp_width, want.w);
				if (out_disp_height !== want.h)
					report_mismatch("height", out_disp_height, want.h);
				if (config_error !== want.err)
					report_mismatch("config_error", config_error, want.err);
			end
			got_count++;
		end
	end

	task automatic test_directed();
		set_all(-1, -1, -1, 1, 0);
		send_size(1, 1, 1, 1);
		send_size(8191, 8191, 8191, 8191);
		send_size(8191, 1, 1, 8191);
		set_all(0, 0, 0, 0, 0);
		send_size(1, 8191, 8191, 1);
		send_size(640, 480, 720, 576);
		set_all(-2, -3, 1, 255, 0);
		send_size(8191, 1, 1, 8191);
		send_size(100, 200, 300, 400);
		set_all(-8192, 8191, 2, 2, 0);
		send_size(1, 8191, 8191, 1);
		send_size(4095, 4095, 4095, 4095);
		set_all(8191, -3, 3, 7, 0);
		send_size(8191, 1, 1, 1);
		send_size(1, 8191, 1, 1);
		set_all(-2, -2, -1, 1, 0);
		send_size(100, 100, 100, 100);
		set_all(-4, -3, -4, 3, 0);
		send_size(100, 100, 100, 100);
		set_all(-1, -1, 0, 1, 65);
		send_size(1920, 1080, 1, 1);
		set_all(-1, -1, 0, 1, 66);
		send_size(8191, 1, 1, 1);
		send_size(1, 8191, 1, 1);
		set_all(-1, -1, 0, 1, 4194303);
		send_size(1, 8191, 1, 1);
		send_size(8191, 8191, 8191, 8191);
		set_all(-3, -3, 0, 1, 116508);
		send_size(1920, 1080, 1, 1);
	endtask

	task automatic test_random(int phases, int per_phase);
		longint fa;
		for (int p = 0; p < phases; p++) begin
			fa = ($urandom_range(0, 2) == 0) ?
				longint'($urandom_range(0, 4194303)) : longint'($urandom_range(0, 70));
			set_all(rand_target(), rand_target(), $urandom_range(0, 7),
				($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3), fa);
			for (int i = 0; i < per_phase; i++)
				send_size(rand_dim(), rand_dim(), rand_dim(), rand_dim());
		end
	endtask

	task automatic test_backpressure();
		set_all(0, -2, 1, 16, 0);
		fork
			begin
				@(negedge clk);
				hold_sink = 1'b1;
				repeat (200) @(negedge clk);
				hold_sink = 1'b0;
			end
			for (int i = 0; i < 80; i++)
				send_size(rand_dim(), rand_dim(), rand_dim(), rand_dim());
		join
		wait_drained();
		for (int i = 0; i < 20; i++)
			send_size(rand_dim(), rand_dim(), rand_dim(), rand_dim());
	endtask

	initial begin
		tw_reg = '1;
		th_reg = '1;
		fm_reg = '1;
		rm_reg = 8'd1;
		fa_reg = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send_size(320, 240, 400, 300);
		test_directed();
		test_random(40, 30);
		test_backpressure();
		idle_enable = 1'b0;
		test_random(4, 40);
		wait_drained();
		$display("sent %0d requests, checked %0d results over many register settings",
			sent_count, got_count);
		if (fail_count == 0 && expected_sizes.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#4ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
